### src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro checks one implication on the
// rising clock edge and is switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/pso_upd_pkg.sv
`timescale 1ns / 1ps

package pso_upd_pkg;

  // Shared multiplier: 33-bit signed operands, full 66-bit product.
  localparam int OpW   = 33;
  localparam int ProdW = 2 * OpW;

  // Fraction bits of the gains and of the random weights.
  localparam int GainFrac = 12;
  localparam int RandFrac = 16;

  // Combined weight k = (c * r) >> GainFrac fits in 22 bits.
  localparam int KW = 16 + 18 - GainFrac;

  // Velocity accumulator holds the exact sum of the three terms.
  localparam int AccW = 42;

  // Distance square root: 64-bit radicand, 32-bit root, one bit per cycle.
  localparam int RadW     = 64;
  localparam int RootW    = RadW / 2;
  localparam int IterCntW = $clog2(RootW);
  localparam logic [IterCntW-1:0] SqrtLast = IterCntW'(RootW - 1);

  localparam logic [31:0] FitInf = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INERTIA = 3'd0,
    CFG_COG     = 3'd1,
    CFG_SOC     = 3'd2,
    CFG_GOAL_X  = 3'd3,
    CFG_GOAL_Y  = 3'd4
  } cfg_idx_e;

  // Saturate a wide signed value to 32-bit signed.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [31:0] r;
    if (v[AccW-1:31] == {(AccW-31){v[AccW-1]}}) begin
      r = v[31:0];
    end else if (v[AccW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

### src/pso_particle_update_core.sv
`timescale 1ns / 1ps

// One two-dimensional particle of a particle swarm. An odometry beat (cmd 0)
// loads the stored position and velocity and returns nothing. A step beat
// (cmd 1) measures the distance from the stored position to the goal, updates
// the particle's own best, picks its own best or the shared swarm best as
// attractor, computes the new velocity w*v + c1*r1*(best - pos) +
// c2*r2*(attractor - pos) and returns pos + v' with the velocity, the fitness,
// the own best and a flag that the shared best should be replaced. The stored
// position is not moved by a step. A step squares and adds the offsets, runs
// the bit-serial square root that yields one root bit per cycle, and then forms
// the weights and the velocity terms; all products run one after another
// through the single registered 33x33 multiplier. When the squared distance
// overflows 64 bits the root is skipped and the fitness reads as all ones. The
// input is ready only while the sequencer is idle; a finished result waits in
// the output register, so the next beat can be taken before it is drained.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i, and the
// user must write it only while the block is idle; the block itself leaves that
// unenforced. Unused indexes are ignored.

`include "assert_macros.svh"

module pso_particle_update_core import pso_upd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [31:0]                cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic signed [31:0]         meas_x_i,
  input  logic signed [31:0]         meas_y_i,
  input  logic signed [31:0]         meas_vel_x_i,
  input  logic signed [31:0]         meas_vel_y_i,
  input  logic signed [31:0]         swarm_best_x_i,
  input  logic signed [31:0]         swarm_best_y_i,
  input  logic [31:0]                swarm_best_fit_i,
  input  logic [17:0]                rand_cog_i,
  input  logic [17:0]                rand_soc_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         next_x_o,
  output logic signed [31:0]         next_y_o,
  output logic signed [31:0]         new_vel_x_o,
  output logic signed [31:0]         new_vel_y_o,
  output logic [31:0]                fitness_now_o,
  output logic [31:0]                own_best_fit_o,
  output logic signed [31:0]         own_best_x_o,
  output logic signed [31:0]         own_best_y_o,
  output logic                       replace_shared_o
);

  // Sequencer states, one-hot. Each product state drives the multiplier
  // operands; the product is read back in the following state.
  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_SQX  = 15'h0002,  // dx * dx
    S_SQY  = 15'h0004,  // dy * dy
    S_SUM  = 15'h0008,  // add squares, launch the root
    S_SQRT = 15'h0010,  // wait for the root
    S_BEST = 15'h0020,  // own best, attractor; c1 * r1
    S_K1   = 15'h0040,  // c2 * r2
    S_K2   = 15'h0080,  // w * vx
    S_IX   = 15'h0100,  // k1 * (best_x - x)
    S_CX   = 15'h0200,  // k2 * (att_x - x)
    S_SX   = 15'h0400,  // vx done; w * vy
    S_IY   = 15'h0800,  // k1 * (best_y - y)
    S_CY   = 15'h1000,  // k2 * (att_y - y)
    S_SY   = 15'h2000,  // vy done
    S_DONE = 15'h4000   // future position into the output register
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0]        w_q, c1_q, c2_q;
  logic signed [31:0] goal_x_q, goal_y_q;

  // Particle state.
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic signed [31:0] best_x_q, best_y_q;
  logic [31:0]        best_fit_q;

  // Step operands captured at acceptance.
  logic signed [31:0] sb_x_q, sb_y_q;
  logic [31:0]        sb_fit_q;
  logic [17:0]        rcog_q, rsoc_q;

  // Working registers.
  logic [RadW-1:0]        sq_q;
  logic [31:0]            fit_q;
  logic [KW-1:0]          k1_q, k2_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [31:0]     att_x_q, att_y_q;
  logic                   repl_q;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] next_x_q, next_y_q, ovel_x_q, ovel_y_q, obest_x_q, obest_y_q;
  logic [31:0]        ofit_q, obest_fit_q;
  logic               orepl_q;

  logic in_fire, out_fire, out_load;

  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic [RadW:0]           sq_sum;
  logic                    sqrt_start, sqrt_done;
  logic [RootW-1:0]        sqrt_root;

  logic signed [OpW-1:0] dx, dy, own_dx, own_dy, att_dx, att_dy;

  logic               best_upd;
  logic [31:0]        best_fit_d;
  logic signed [31:0] best_x_d, best_y_d;
  logic               repl_d;

  logic signed [AccW-1:0] inert_t, gain_t, vel_sum, nx_sum, ny_sum;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Offsets as 33-bit signed values; none of them can overflow.
  assign dx     = {goal_x_q[31], goal_x_q} - {pos_x_q[31], pos_x_q};
  assign dy     = {goal_y_q[31], goal_y_q} - {pos_y_q[31], pos_y_q};
  assign own_dx = {best_x_q[31], best_x_q} - {pos_x_q[31], pos_x_q};
  assign own_dy = {best_y_q[31], best_y_q} - {pos_y_q[31], pos_y_q};
  assign att_dx = {att_x_q[31], att_x_q} - {pos_x_q[31], pos_x_q};
  assign att_dy = {att_y_q[31], att_y_q} - {pos_y_q[31], pos_y_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_SQX: begin
        op_a = dx;
        op_b = dx;
      end
      S_SQY: begin
        op_a = dy;
        op_b = dy;
      end
      S_BEST: begin
        op_a = {{(OpW-16){1'b0}}, c1_q};
        op_b = {{(OpW-18){1'b0}}, rcog_q};
      end
      S_K1: begin
        op_a = {{(OpW-16){1'b0}}, c2_q};
        op_b = {{(OpW-18){1'b0}}, rsoc_q};
      end
      S_K2: begin
        op_a = {{(OpW-16){1'b0}}, w_q};
        op_b = {vel_x_q[31], vel_x_q};
      end
      S_IX: begin
        op_a = {{(OpW-KW){1'b0}}, k1_q};
        op_b = own_dx;
      end
      S_CX: begin
        op_a = {{(OpW-KW){1'b0}}, k2_q};
        op_b = att_dx;
      end
      S_SX: begin
        op_a = {{(OpW-16){1'b0}}, w_q};
        op_b = {vel_y_q[31], vel_y_q};
      end
      S_IY: begin
        op_a = {{(OpW-KW){1'b0}}, k1_q};
        op_b = own_dy;
      end
      S_CY: begin
        op_a = {{(OpW-KW){1'b0}}, k2_q};
        op_b = att_dy;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  pso_upd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  // Both squares are non-negative and below 2^64; a carry out means infinity.
  assign sq_sum     = {1'b0, sq_q} + {1'b0, prod[RadW-1:0]};
  assign sqrt_start = (state_q == S_SUM) && !sq_sum[RadW];

  pso_upd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sq_sum[RadW-1:0]),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  // Own best moves only on a strictly smaller fitness, then the attractor
  // follows whichever of own best and swarm best is better.
  assign best_upd   = fit_q < best_fit_q;
  assign best_fit_d = best_upd ? fit_q : best_fit_q;
  assign best_x_d   = best_upd ? pos_x_q : best_x_q;
  assign best_y_d   = best_upd ? pos_y_q : best_y_q;
  assign repl_d     = best_fit_d < sb_fit_q;

  // Floor shifts are plain slices of the signed product; the kept bits hold
  // the whole value, so the slice keeps its sign.
  assign inert_t = prod[GainFrac+AccW-1:GainFrac];
  assign gain_t  = prod[RandFrac+AccW-1:RandFrac];
  assign vel_sum = acc_q + gain_t;

  assign nx_sum = {{(AccW-32){pos_x_q[31]}}, pos_x_q} + {{(AccW-32){vel_x_q[31]}}, vel_x_q};
  assign ny_sum = {{(AccW-32){pos_y_q[31]}}, pos_y_q} + {{(AccW-32){vel_y_q[31]}}, vel_y_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && cmd_i) begin
          state_d = S_SQX;
        end
      end
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_SUM;
      S_SUM:  state_d = sq_sum[RadW] ? S_BEST : S_SQRT;
      S_SQRT: begin
        if (sqrt_done) begin
          state_d = S_BEST;
        end
      end
      S_BEST: state_d = S_K1;
      S_K1:   state_d = S_K2;
      S_K2:   state_d = S_IX;
      S_IX:   state_d = S_CX;
      S_CX:   state_d = S_SX;
      S_SX:   state_d = S_IY;
      S_IY:   state_d = S_CY;
      S_CY:   state_d = S_SY;
      S_SY:   state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      w_q         <= 16'd3482;
      c1_q        <= 16'd4096;
      c2_q        <= 16'd8192;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_fit_q  <= FitInf;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INERTIA: w_q      <= cfg_data_i[15:0];
          CFG_COG:     c1_q     <= cfg_data_i[15:0];
          CFG_SOC:     c2_q     <= cfg_data_i[15:0];
          CFG_GOAL_X:  goal_x_q <= cfg_data_i;
          CFG_GOAL_Y:  goal_y_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_fire && !cmd_i) begin
        pos_x_q <= meas_x_i;
        pos_y_q <= meas_y_i;
        vel_x_q <= meas_vel_x_i;
        vel_y_q <= meas_vel_y_i;
      end

      if (state_q == S_BEST) begin
        best_fit_q <= best_fit_d;
        best_x_q   <= best_x_d;
        best_y_q   <= best_y_d;
      end

      if (state_q == S_SX) begin
        vel_x_q <= sat32(vel_sum);
      end
      if (state_q == S_SY) begin
        vel_y_q <= sat32(vel_sum);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd_i) begin
      sb_x_q   <= swarm_best_x_i;
      sb_y_q   <= swarm_best_y_i;
      sb_fit_q <= swarm_best_fit_i;
      rcog_q   <= rand_cog_i;
      rsoc_q   <= rand_soc_i;
    end

    case (state_q)
      S_SQY: sq_q <= prod[RadW-1:0];
      S_SUM: fit_q <= FitInf;
      S_SQRT: begin
        if (sqrt_done) begin
          fit_q <= sqrt_root;
        end
      end
      S_BEST: begin
        repl_q  <= repl_d;
        att_x_q <= repl_d ? best_x_d : sb_x_q;
        att_y_q <= repl_d ? best_y_d : sb_y_q;
      end
      S_K1: k1_q <= prod[GainFrac+KW-1:GainFrac];
      S_K2: k2_q <= prod[GainFrac+KW-1:GainFrac];
      S_IX: acc_q <= inert_t;
      S_CX: acc_q <= vel_sum;
      S_IY: acc_q <= inert_t;
      S_CY: acc_q <= vel_sum;
      default: ;
    endcase

    if (out_load) begin
      next_x_q    <= sat32(nx_sum);
      next_y_q    <= sat32(ny_sum);
      ovel_x_q    <= vel_x_q;
      ovel_y_q    <= vel_y_q;
      ofit_q      <= fit_q;
      obest_fit_q <= best_fit_q;
      obest_x_q   <= best_x_q;
      obest_y_q   <= best_y_q;
      orepl_q     <= repl_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_x_o         = next_x_q;
  assign next_y_o         = next_y_q;
  assign new_vel_x_o      = ovel_x_q;
  assign new_vel_y_o      = ovel_y_q;
  assign fitness_now_o    = ofit_q;
  assign own_best_fit_o   = obest_fit_q;
  assign own_best_x_o     = obest_x_q;
  assign own_best_y_o     = obest_y_q;
  assign replace_shared_o = orepl_q;

  `ASSERT_IMP(a_root_in_wait, clk_i, rst_ni, sqrt_done, state_q == S_SQRT)
  `ASSERT_NXT(a_step_starts, clk_i, rst_ni, in_fire && cmd_i, state_q == S_SQX)
  `ASSERT_NXT(a_hold_result, clk_i, rst_ni, state_q == S_DONE && out_valid_q && !out_ready_i, state_q == S_DONE)
  `ASSERT_NXT(a_best_no_rise, clk_i, rst_ni, 1'b1, best_fit_q <= $past(best_fit_q))

endmodule

### src/pso_upd_mul.sv
`timescale 1ns / 1ps

module pso_upd_mul import pso_upd_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [OpW-1:0]   a_i,
  input  logic signed [OpW-1:0]   b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_d;
  logic signed [ProdW-1:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### src/pso_upd_sqrt.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pso_upd_sqrt import pso_upd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic [RootW-1:0] root_o,
  output logic             done_o
);

  logic                busy_q;
  logic                done_q;
  logic [IterCntW-1:0] cnt_q;
  logic [RadW-1:0]     rad_q;
  logic [RootW+1:0]    rem_q;
  logic [RootW-1:0]    root_q;

  logic [RootW+3:0]    rem_sh;
  logic [RootW+3:0]    trial;
  logic                take;
  logic [RootW+1:0]    rem_d;
  logic [RootW-1:0]    root_d;

  // Restoring digit recurrence: two radicand bits in, one root bit out.
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = rem_sh >= trial;
  assign rem_d  = take ? (RootW+2)'(rem_sh - trial) : (RootW+2)'(rem_sh);
  assign root_d = {root_q[RootW-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + IterCntW'(1);
        if (cnt_q == SqrtLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

  `ASSERT_IMP(a_start_idle, clk_i, rst_ni, start_i, !busy_q)
  `ASSERT_NXT(a_last_done, clk_i, rst_ni, busy_q && !start_i && cnt_q == SqrtLast, done_q)
  `ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q)

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Block-level bench for the particle update core.
//
// Beats are queued by the stimulus thread and handed to the block by a clocked
// driver. The driver runs a model of the particle on every beat that the block
// accepts and queues the expected move of each step. A clocked monitor drains
// the result channel and compares every field of each result beat against the
// oldest queued move. The run steps through several gain and goal settings, and
// the two sides idle and stall at different rates from one phase to the next.

module tb import pso_upd_pkg::*; ();

  localparam logic CMD_ODOM = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic signed [31:0] MaxQ = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinQ = 32'sh8000_0000;
  localparam logic [17:0] RandTwo = 18'd131072;
  localparam logic [17:0] RandTop = '1;

  // The pause before a register write is longer than a step.
  localparam int SettleCycles = 64;
  // Cycles with no beat on either channel before the run is called hung.
  localparam int QuietLimit = 4000;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_vel_x;
    logic signed [31:0] meas_vel_y;
    logic signed [31:0] swarm_x;
    logic signed [31:0] swarm_y;
    logic [31:0]        swarm_fit;
    logic [17:0]        r_cog;
    logic [17:0]        r_soc;
  } particle_beat_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        fit;
    logic [31:0]        best_fit;
    logic signed [31:0] best_x;
    logic signed [31:0] best_y;
    logic               replace;
  } particle_move_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [31:0]         cfg_data_i = '0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                cmd_i = 1'b0;
  logic signed [31:0]  meas_x_i = '0;
  logic signed [31:0]  meas_y_i = '0;
  logic signed [31:0]  meas_vel_x_i = '0;
  logic signed [31:0]  meas_vel_y_i = '0;
  logic signed [31:0]  swarm_best_x_i = '0;
  logic signed [31:0]  swarm_best_y_i = '0;
  logic [31:0]         swarm_best_fit_i = '0;
  logic [17:0]         rand_cog_i = '0;
  logic [17:0]         rand_soc_i = '0;

  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [31:0]  next_x_o;
  logic signed [31:0]  next_y_o;
  logic signed [31:0]  new_vel_x_o;
  logic signed [31:0]  new_vel_y_o;
  logic [31:0]         fitness_now_o;
  logic [31:0]         own_best_fit_o;
  logic signed [31:0]  own_best_x_o;
  logic signed [31:0]  own_best_y_o;
  logic                replace_shared_o;

  pso_particle_update_core u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .meas_x_i,
    .meas_y_i,
    .meas_vel_x_i,
    .meas_vel_y_i,
    .swarm_best_x_i,
    .swarm_best_y_i,
    .swarm_best_fit_i,
    .rand_cog_i,
    .rand_soc_i,
    .out_valid_o,
    .out_ready_i,
    .next_x_o,
    .next_y_o,
    .new_vel_x_o,
    .new_vel_y_o,
    .fitness_now_o,
    .own_best_fit_o,
    .own_best_x_o,
    .own_best_y_o,
    .replace_shared_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Beats waiting for the driver, and moves waiting for the monitor.
  particle_beat_t pending[$];
  particle_move_t exp_moves[$];
  particle_beat_t cur_beat;
  pace_e          pace = PACE_FULL;
  int             err_cnt = 0;
  int             quiet_cycles = 0;

  // Model copy of the registers and of the particle state, as after reset.
  logic [15:0]        w_gain = 16'd3482;
  logic [15:0]        c1_gain = 16'd4096;
  logic [15:0]        c2_gain = 16'd8192;
  logic signed [31:0] goal_x_q = '0;
  logic signed [31:0] goal_y_q = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] vel_x = '0;
  logic signed [31:0] vel_y = '0;
  logic signed [31:0] best_x = '0;
  logic signed [31:0] best_y = '0;
  logic [31:0]        best_fitness = FitInf;

  function automatic void apply_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    case (idx)
      CFG_INERTIA: w_gain = data[15:0];
      CFG_COG:     c1_gain = data[15:0];
      CFG_SOC:     c2_gain = data[15:0];
      CFG_GOAL_X:  goal_x_q = data;
      CFG_GOAL_Y:  goal_y_q = data;
      default: ;
    endcase
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return MaxQ;
    if (v < -64'sh8000_0000) return MinQ;
    return v[31:0];
  endfunction

  // Euclidean distance to the goal, floor of the root. A squared sum that
  // does not fit in 64 bits reads as infinity.
  function automatic logic [31:0] dist_to_goal(logic signed [31:0] px, py);
    longint      dx, dy;
    logic [63:0] ax, ay, trial;
    logic [64:0] sq_sum;
    logic [31:0] root;
    dx = longint'(goal_x_q) - longint'(px);
    dy = longint'(goal_y_q) - longint'(py);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq_sum = {1'b0, ax * ax} + {1'b0, ay * ay};
    if (sq_sum[64]) return FitInf;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      root[b] = 1'b1;
      trial = {32'b0, root};
      if (trial * trial > sq_sum[63:0]) root[b] = 1'b0;
    end
    return root;
  endfunction

  // One velocity axis: inertia plus the two pulls, each term floored on its
  // own, summed exactly and then saturated.
  function automatic logic signed [31:0] vel_update(logic signed [31:0] v, pos, own, att,
                                                    logic [17:0] r1, r2);
    longint k1, k2, acc;
    k1 = (longint'(c1_gain) * longint'(r1)) >>> GainFrac;
    k2 = (longint'(c2_gain) * longint'(r2)) >>> GainFrac;
    acc = ((longint'(w_gain) * longint'(v)) >>> GainFrac)
        + ((k1 * (longint'(own) - longint'(pos))) >>> RandFrac)
        + ((k2 * (longint'(att) - longint'(pos))) >>> RandFrac);
    return clamp32(acc);
  endfunction

  // Advances the particle by one accepted beat and queues the move that a
  // step beat must produce. An odometry beat only reloads the state.
  function automatic void predict_particle(particle_beat_t b);
    particle_move_t m;
    logic signed [31:0] att_x, att_y;
    if (b.cmd == CMD_ODOM) begin
      pos_x = b.meas_x;
      pos_y = b.meas_y;
      vel_x = b.meas_vel_x;
      vel_y = b.meas_vel_y;
      return;
    end
    m.fit = dist_to_goal(pos_x, pos_y);
    // Only a strictly smaller fitness moves the own best, so a saturated
    // distance never displaces the infinite best left by reset.
    if (m.fit < best_fitness) begin
      best_fitness = m.fit;
      best_x = pos_x;
      best_y = pos_y;
    end
    m.replace = best_fitness < b.swarm_fit;
    att_x = m.replace ? best_x : b.swarm_x;
    att_y = m.replace ? best_y : b.swarm_y;
    vel_x = vel_update(vel_x, pos_x, best_x, att_x, b.r_cog, b.r_soc);
    vel_y = vel_update(vel_y, pos_y, best_y, att_y, b.r_cog, b.r_soc);
    m.next_x = clamp32(longint'(pos_x) + longint'(vel_x));
    m.next_y = clamp32(longint'(pos_y) + longint'(vel_y));
    m.vel_x = vel_x;
    m.vel_y = vel_y;
    m.best_fit = best_fitness;
    m.best_x = best_x;
    m.best_y = best_y;
    exp_moves.push_back(m);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, e, a);
    end
  endfunction

  function automatic bit tx_idle();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 86;
      PACE_BOTH:      return $urandom_range(0, 99) < 7;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit rx_stall();
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(0, 99) < 86;
      PACE_BOTH:        return $urandom_range(0, 99) < 7;
      default:          return 1'b0;
    endcase
  endfunction

  // Driver. A beat is predicted at the edge where it is accepted. Valid is
  // assigned once per edge, so a beat that follows straight on keeps it high.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_particle(cur_beat);
      if (!in_valid_i || in_ready_o) begin
        if (pending.size() != 0 && !tx_idle()) begin
          cur_beat = pending.pop_front();
          in_valid_i       <= 1'b1;
          cmd_i            <= cur_beat.cmd;
          meas_x_i         <= cur_beat.meas_x;
          meas_y_i         <= cur_beat.meas_y;
          meas_vel_x_i     <= cur_beat.meas_vel_x;
          meas_vel_y_i     <= cur_beat.meas_vel_y;
          swarm_best_x_i   <= cur_beat.swarm_x;
          swarm_best_y_i   <= cur_beat.swarm_y;
          swarm_best_fit_i <= cur_beat.swarm_fit;
          rand_cog_i       <= cur_beat.r_cog;
          rand_soc_i       <= cur_beat.r_soc;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result beat is checked against the oldest queued move.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (exp_moves.size() == 0) begin
          err_cnt++;
          $display("%0t ns: result beat with no step outstanding, next_x %h", $time,
                   next_x_o);
        end else begin
          cmp_field("next_x", exp_moves[0].next_x, next_x_o);
          cmp_field("next_y", exp_moves[0].next_y, next_y_o);
          cmp_field("new_vel_x", exp_moves[0].vel_x, new_vel_x_o);
          cmp_field("new_vel_y", exp_moves[0].vel_y, new_vel_y_o);
          cmp_field("fitness_now", exp_moves[0].fit, fitness_now_o);
          cmp_field("own_best_fit", exp_moves[0].best_fit, own_best_fit_o);
          cmp_field("own_best_x", exp_moves[0].best_x, own_best_x_o);
          cmp_field("own_best_y", exp_moves[0].best_y, own_best_y_o);
          cmp_field("replace_shared", 32'(exp_moves[0].replace), 32'(replace_shared_o));
          void'(exp_moves.pop_front());
        end
      end
      out_ready_i <= !rx_stall();
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Coordinates spread over every magnitude, with the extremes and points
  // close to a given center mixed in.
  function automatic logic signed [31:0] pick_coord(logic signed [31:0] center);
    logic signed [31:0] mag;
    mag = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) mag = -mag;
    case ($urandom_range(0, 9))
      0:       return MaxQ;
      1:       return MinQ;
      2:       return $urandom;
      3, 4, 5: return center + ($urandom_range(0, 1) ? mag >>> 8 : -(mag >>> 8));
      default: return mag;
    endcase
  endfunction

  function automatic logic [17:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RandTwo;
      2:       return 18'($urandom_range(0, RandTop));
      default: return 18'($urandom_range(0, RandTwo));
    endcase
  endfunction

  function automatic logic [31:0] pick_swarm_fit();
    case ($urandom_range(0, 7))
      0:       return FitInf;
      1:       return '0;
      2:       return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Fields that a beat's command ignores still carry random bits.
  function automatic particle_beat_t make_odo(logic signed [31:0] px, py, vx, vy);
    particle_beat_t b;
    b = {CMD_ODOM, px, py, vx, vy, 32'($urandom), 32'($urandom), 32'($urandom),
         18'($urandom), 18'($urandom)};
    return b;
  endfunction

  function automatic particle_beat_t make_step(logic signed [31:0] sx, sy,
                                               logic [31:0] sfit, logic [17:0] r1, r2);
    particle_beat_t b;
    b = {CMD_STEP, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
         sx, sy, sfit, r1, r2};
    return b;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_cfg(idx, data);
  endtask

  // Writes all five registers; the unused indexes get random data, which the
  // block must drop.
  task automatic program_cfg(input logic [15:0] w, c1, c2, input logic [31:0] gx, gy);
    write_reg(CFG_INERTIA, {16'($urandom), w});
    write_reg(CFG_COG, {16'($urandom), c1});
    write_reg(CFG_SOC, {16'($urandom), c2});
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
    for (int i = CFG_GOAL_Y + 1; i < (1 << CfgIdxW); i++) write_reg(CfgIdxW'(i), $urandom);
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || exp_moves.size() != 0);
  endtask

  // Hands over one beat and holds back until its result, if any, has drained.
  task automatic send_alone(input particle_beat_t b);
    pending.push_back(b);
    wait_quiet();
  endtask

  // One random phase: mostly an odometry beat followed by a few steps from
  // that position, now and then two odometry beats in a row.
  task automatic run_phase(input int p, input int n_beats);
    int sent;
    int n_steps;
    wait_quiet();
    repeat (SettleCycles) @(negedge clk_i);
    case (p)
      0:       program_cfg(16'd3482, 16'd4096, 16'd8192, pick_coord(0), pick_coord(0));
      1:       program_cfg('1, '1, '1, pick_coord(0), pick_coord(0));
      2:       program_cfg('0, '0, '0, pick_coord(0), pick_coord(0));
      3:       program_cfg(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 16383)),
                           16'($urandom_range(0, 16383)), MaxQ, MinQ);
      default: program_cfg(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 16383)), pick_coord(0), pick_coord(0));
    endcase
    pace = pace_e'(p % 4);
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) == 0) begin
        pending.push_back(make_odo($urandom, $urandom, $urandom, $urandom));
        sent++;
      end
      pending.push_back(make_odo(pick_coord(goal_x_q), pick_coord(goal_y_q),
                                 pick_coord(0), pick_coord(0)));
      n_steps = $urandom_range(1, 4);
      repeat (n_steps)
        pending.push_back(make_step(pick_coord(goal_x_q), pick_coord(goal_y_q),
                                    pick_swarm_fit(), pick_weight(), pick_weight()));
      sent += 1 + n_steps;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed start, one beat at a time. The goal sits in the far corner, so
    // the first step from the opposite corner overflows the squared distance
    // and must leave the infinite reset best in place.
    program_cfg(16'd3482, 16'd4096, 16'd8192, MaxQ, MaxQ);
    send_alone(make_odo(MinQ, MinQ, MaxQ, MinQ));
    send_alone(make_step(MaxQ, MinQ, FitInf, '0, RandTop));
    send_alone(make_step('0, '0, '0, RandTop, '0));
    send_alone(make_odo('0, '0, '0, '0));
    // First finite fitness: the own best moves and beats an infinite swarm best.
    send_alone(make_step(MinQ, MaxQ, FitInf, RandTwo, RandTwo));
    // A swarm best equal to the own best is not beaten.
    send_alone(make_step(32'sd1, -32'sd1, dist_to_goal('0, '0), pick_weight(),
                         pick_weight()));
    send_alone(make_odo(MaxQ - 32'sd65536, MaxQ - 32'sd65536, -32'sd1, 32'sd1));
    send_alone(make_step($urandom, $urandom, FitInf, pick_weight(), pick_weight()));
    send_alone(make_step($urandom, $urandom, 32'd1, RandTop, RandTop));

    for (int p = 0; p < 8; p++) run_phase(p, 140);

    // Directed end with all gains at full scale and the goal in the negative
    // corner: a saturated distance after a finite best, velocities that clip
    // at both rails, and finally a position right on the goal.
    wait_quiet();
    repeat (SettleCycles) @(negedge clk_i);
    program_cfg('1, '1, '1, MinQ, MinQ);
    pace = PACE_FULL;
    send_alone(make_odo(MaxQ, MaxQ, MaxQ, MaxQ));
    send_alone(make_step(MaxQ, MaxQ, FitInf, RandTop, RandTop));
    send_alone(make_odo(MinQ, MinQ, MinQ, MinQ));
    send_alone(make_step(MaxQ, MinQ, '0, RandTwo, RandTwo));
    send_alone(make_step(MinQ, MaxQ, 32'd1, RandTop, RandTop));

    wait_quiet();
    repeat (SettleCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### pso_particle_update_core.f
+incdir+src
src/pso_upd_pkg.sv
src/pso_upd_mul.sv
src/pso_upd_sqrt.sv
src/pso_particle_update_core.sv
tb/tb.sv
